FILE: src/pstw_pkg.sv
`timescale 1ns / 1ps
// package for the pid steering core with twiddle tuning
// widths, codes and the structs passed between pipeline stages; no dependencies
package pstw_pkg;

  localparam int GAIN_WIDTH  = 24;
  localparam int ERROR_WIDTH = 16;
  localparam int SUM_WIDTH   = 32;

  localparam int STEP_WIDTH  = GAIN_WIDTH - 1;
  localparam int TOTAL_WIDTH = 32;
  localparam int REQ_WIDTH   = 2;
  localparam int IDX_WIDTH   = 2;
  localparam int PHASE_WIDTH = 2;
  localparam int NUM_GAINS   = 3;

  localparam int DIFF_WIDTH = ERROR_WIDTH + 1;
  localparam int PP_WIDTH   = GAIN_WIDTH + ERROR_WIDTH;
  localparam int PD_WIDTH   = GAIN_WIDTH + DIFF_WIDTH;
  localparam int PI_WIDTH   = GAIN_WIDTH + SUM_WIDTH;
  localparam int ACC_WIDTH  = PI_WIDTH + 2;

  localparam int STEER_WIDTH     = 16;
  localparam int STEER_ONE_SHIFT = 26;
  localparam int ROUND_SHIFT     = 12;
  localparam int STEER_CLAMP     = 13107;

  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = GAIN_WIDTH;

  localparam int IN_FIELDS_WIDTH  = ERROR_WIDTH + TOTAL_WIDTH;
  localparam int IN_TDATA_WIDTH   = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_WIDTH = STEER_WIDTH + 3 * GAIN_WIDTH + TOTAL_WIDTH
                                    + IDX_WIDTH + PHASE_WIDTH;
  localparam int OUT_TDATA_WIDTH  = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH    = OUT_TDATA_WIDTH - OUT_FIELDS_WIDTH;

  // configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_GAIN_P = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_GAIN_D = CFG_IDX_WIDTH'(1);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_GAIN_I = CFG_IDX_WIDTH'(2);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_STEP_P = CFG_IDX_WIDTH'(3);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_STEP_D = CFG_IDX_WIDTH'(4);
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INIT_STEP_I = CFG_IDX_WIDTH'(5);

  typedef enum logic [REQ_WIDTH-1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TUNE   = 2'd1,
    REQ_INIT   = 2'd2
  } req_e;

  typedef enum logic [PHASE_WIDTH-1:0] {
    PH_TRY_UP     = 2'd0,
    PH_JUDGE_UP   = 2'd1,
    PH_JUDGE_DOWN = 2'd2
  } phase_e;

  typedef struct packed {
    logic signed [GAIN_WIDTH-1:0] gain_p;
    logic signed [GAIN_WIDTH-1:0] gain_d;
    logic signed [GAIN_WIDTH-1:0] gain_i;
    logic [TOTAL_WIDTH-1:0]       best;
    logic [IDX_WIDTH-1:0]         tune_idx;
    phase_e                       phase;
  } stat_t;

  typedef struct packed {
    logic                          is_sample;
    logic signed [ERROR_WIDTH-1:0] cte;
    logic signed [DIFF_WIDTH-1:0]  diff;
    logic signed [SUM_WIDTH-1:0]   sum;
    stat_t                         stat;
  } op_t;

  typedef struct packed {
    logic                       is_sample;
    logic signed [PP_WIDTH-1:0] pp;
    logic signed [PD_WIDTH-1:0] pd;
    logic signed [PI_WIDTH-1:0] pi;
    stat_t                      stat;
  } prod_t;

  // last field declared in the lowest bits
  typedef struct packed {
    logic [OUT_PAD_WIDTH-1:0]      pad;
    logic [PHASE_WIDTH-1:0]        phase;
    logic [IDX_WIDTH-1:0]          tune_idx;
    logic [TOTAL_WIDTH-1:0]        best;
    logic signed [GAIN_WIDTH-1:0]  gain_i;
    logic signed [GAIN_WIDTH-1:0]  gain_d;
    logic signed [GAIN_WIDTH-1:0]  gain_p;
    logic signed [STEER_WIDTH-1:0] steer;
  } result_t;

endpackage

FILE: src/pid_steer_with_twiddle_tuning_core.sv
`timescale 1ns / 1ps
// top level of the pid steering core with three-phase twiddle gain tuning
// ties pstw_ctrl, pstw_mac and pstw_out together; uses pstw_pkg
//
//   channel   dir   width  payload
//   s_axis    in    48+2   tdata: cross_track_error, run_total; tuser: req_type
//   m_axis    out   128    tdata: steer_cmd, gains p/d/i, best, index, phase
//   cfg       in    3+24   register index and write data, always ready
//
// one item per cycle sustained while the output is ready; each item taken is registered
// in turn by the state stage, the multiplier stage and the sum/clamp stage
// each stage has its own valid and holds when the next one is full, so bubbles
// close up and a stalled output still lets items enter behind it
// reset clears the state, the config registers and all stage valids
module pid_steer_with_twiddle_tuning_core import pstw_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cross_track_error [15:0], run_total [47:16]
  input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // req_type [1:0]
  input  logic [REQ_WIDTH-1:0]       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // steer_cmd [15:0], gain_p_now [39:16], gain_d_now [63:40], gain_i_now [87:64],
  // best_error_now [119:88], index_now [121:120], phase_now [123:122], zeros above
  output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  logic    op_valid, op_ready;
  op_t     op;
  logic    prod_valid, prod_ready;
  prod_t   prod;
  result_t res;

  assign cfg_ready_o = 1'b1;

  pstw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_type_i  (s_axis_tuser),
    .cte_i       (s_axis_tdata[ERROR_WIDTH-1:0]),
    .total_i     (s_axis_tdata[ERROR_WIDTH +: TOTAL_WIDTH]),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_o        (op)
  );

  pstw_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (op_valid),
    .op_ready_o   (op_ready),
    .op_i         (op),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  pstw_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = res;

endmodule

FILE: src/pstw_ctrl.sv
`timescale 1ns / 1ps
// front stage: configuration registers, controller state and the twiddle step
// applies each accepted item to the state and registers the operands; uses pstw_pkg
module pstw_ctrl import pstw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [REQ_WIDTH-1:0]      req_type_i,
  input  logic [ERROR_WIDTH-1:0]    cte_i,
  input  logic [TOTAL_WIDTH-1:0]    total_i,
  output logic                      op_valid_o,
  input  logic                      op_ready_i,
  output op_t                       op_o
);

  localparam int GE_WIDTH    = GAIN_WIDTH + 2;
  localparam int SE_WIDTH    = SUM_WIDTH + 1;
  localparam int SX_WIDTH    = STEP_WIDTH + 4;
  localparam int RECIP_SHIFT = SX_WIDTH + 4;
  localparam int RECIP_WIDTH = RECIP_SHIFT - 2;
  localparam int SP_WIDTH    = SX_WIDTH + RECIP_WIDTH;
  localparam longint unsigned RecipTenL = ((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10;
  localparam logic [RECIP_WIDTH-1:0] RecipTen = RECIP_WIDTH'(RecipTenL);
  localparam logic [STEP_WIDTH-1:0] StepMax = '1;
  localparam logic signed [GE_WIDTH-1:0] GainHi = GE_WIDTH'((64'd1 << (GAIN_WIDTH - 1)) - 1);
  localparam logic signed [GE_WIDTH-1:0] GainLo = -GainHi - GE_WIDTH'(1);
  localparam logic signed [SE_WIDTH-1:0] SumHi = SE_WIDTH'((64'd1 << (SUM_WIDTH - 1)) - 1);
  localparam logic signed [SE_WIDTH-1:0] SumLo = -SumHi - SE_WIDTH'(1);
  localparam logic [IDX_WIDTH-1:0] LastIdx = IDX_WIDTH'(NUM_GAINS - 1);

  function automatic logic signed [GAIN_WIDTH-1:0] sat_gain(
    input logic signed [GE_WIDTH-1:0] x
  );
    logic signed [GAIN_WIDTH-1:0] r;
    if (x > GainHi) begin
      r = GainHi[GAIN_WIDTH-1:0];
    end else if (x < GainLo) begin
      r = GainLo[GAIN_WIDTH-1:0];
    end else begin
      r = x[GAIN_WIDTH-1:0];
    end
    return r;
  endfunction

  logic signed [GAIN_WIDTH-1:0]  cfg_gain_q [NUM_GAINS];
  logic [STEP_WIDTH-1:0]         cfg_step_q [NUM_GAINS];

  logic signed [GAIN_WIDTH-1:0]  gains_q [NUM_GAINS];
  logic signed [GAIN_WIDTH-1:0]  gains_d [NUM_GAINS];
  logic [STEP_WIDTH-1:0]         steps_q [NUM_GAINS];
  logic [STEP_WIDTH-1:0]         steps_d [NUM_GAINS];
  logic signed [ERROR_WIDTH-1:0] last_q, last_d;
  logic signed [SUM_WIDTH-1:0]   sum_q, sum_d;
  logic [TOTAL_WIDTH-1:0]        best_q, best_d;
  logic [IDX_WIDTH-1:0]          index_q, index_d;
  phase_e                        phase_q, phase_d;
  logic                          valid_q, valid_d;
  op_t                           op_q, op_d;

  logic                          accept;
  logic signed [ERROR_WIDTH-1:0] cte;
  logic [IDX_WIDTH-1:0]          k, k_next;
  logic signed [GAIN_WIDTH-1:0]  g_sel, g_up, g_down;
  logic [STEP_WIDTH-1:0]         s_sel, s_scaled;
  logic                          lt, grow;
  logic [SX_WIDTH-1:0]           scale_x;
  logic [SP_WIDTH-1:0]           scale_p, scale_q;
  logic signed [SE_WIDTH-1:0]    sum_ext;

  assign in_ready_o = !valid_q || op_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cte        = $signed(cte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        cfg_gain_q[i] <= '0;
        cfg_step_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INIT_GAIN_P: cfg_gain_q[0] <= $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_INIT_GAIN_D: cfg_gain_q[1] <= $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_INIT_GAIN_I: cfg_gain_q[2] <= $signed(cfg_data_i[GAIN_WIDTH-1:0]);
        CFG_INIT_STEP_P: cfg_step_q[0] <= cfg_data_i[STEP_WIDTH-1:0];
        CFG_INIT_STEP_D: cfg_step_q[1] <= cfg_data_i[STEP_WIDTH-1:0];
        CFG_INIT_STEP_I: cfg_step_q[2] <= cfg_data_i[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // twiddle datapath for the gain under tune
  always_comb begin
    k      = (index_q > LastIdx) ? '0 : index_q;
    k_next = (k == LastIdx) ? '0 : k + 1'b1;
    g_sel  = gains_q[k];
    s_sel  = steps_q[k];
    lt     = total_i < best_q;
    grow   = lt && (phase_q == PH_JUDGE_UP || phase_q == PH_JUDGE_DOWN);
    g_up   = sat_gain(GE_WIDTH'(g_sel) + GE_WIDTH'($signed({1'b0, s_sel})));
    g_down = sat_gain(GE_WIDTH'(g_sel) - GE_WIDTH'($signed({1'b0, s_sel, 1'b0})));
    // step * 1.1 or * 0.9, half up, divide by ten through a reciprocal
    scale_x = grow ? SX_WIDTH'(s_sel) * SX_WIDTH'(11) + SX_WIDTH'(5)
                   : SX_WIDTH'(s_sel) * SX_WIDTH'(9) + SX_WIDTH'(5);
    scale_p = SP_WIDTH'(scale_x) * SP_WIDTH'(RecipTen);
    scale_q = scale_p >> RECIP_SHIFT;
    s_scaled = (scale_q > SP_WIDTH'(StepMax)) ? StepMax : scale_q[STEP_WIDTH-1:0];
    sum_ext = SE_WIDTH'(sum_q) + SE_WIDTH'(cte);
  end

  always_comb begin
    gains_d = gains_q;
    steps_d = steps_q;
    last_d  = last_q;
    sum_d   = sum_q;
    best_d  = best_q;
    index_d = index_q;
    phase_d = phase_q;
    if (accept) begin
      case (req_e'(req_type_i))
        REQ_SAMPLE: begin
          last_d = cte;
          if (sum_ext > SumHi) begin
            sum_d = SumHi[SUM_WIDTH-1:0];
          end else if (sum_ext < SumLo) begin
            sum_d = SumLo[SUM_WIDTH-1:0];
          end else begin
            sum_d = sum_ext[SUM_WIDTH-1:0];
          end
        end
        REQ_TUNE: begin
          index_d = k;
          case (phase_q)
            PH_JUDGE_UP: begin
              if (lt) begin
                best_d     = total_i;
                steps_d[k] = s_scaled;
                index_d    = k_next;
                phase_d    = PH_TRY_UP;
              end else begin
                gains_d[k] = g_down;
                phase_d    = PH_JUDGE_DOWN;
              end
            end
            PH_JUDGE_DOWN: begin
              if (lt) begin
                best_d = total_i;
              end else begin
                gains_d[k] = g_up;
              end
              steps_d[k] = s_scaled;
              index_d    = k_next;
              phase_d    = PH_TRY_UP;
            end
            default: begin
              best_d     = total_i;
              gains_d[k] = g_up;
              phase_d    = PH_JUDGE_UP;
            end
          endcase
        end
        REQ_INIT: begin
          sum_d   = '0;
          gains_d = cfg_gain_q;
          steps_d = cfg_step_q;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    valid_d = accept || (valid_q && !op_ready_i);
    op_d.is_sample     = (req_type_i == REQ_SAMPLE);
    op_d.cte           = cte;
    op_d.diff          = DIFF_WIDTH'(cte) - DIFF_WIDTH'(last_q);
    op_d.sum           = sum_d;
    op_d.stat.gain_p   = gains_d[0];
    op_d.stat.gain_d   = gains_d[1];
    op_d.stat.gain_i   = gains_d[2];
    op_d.stat.best     = best_d;
    op_d.stat.tune_idx = index_d;
    op_d.stat.phase    = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        gains_q[i] <= '0;
        steps_q[i] <= '0;
      end
      last_q  <= '0;
      sum_q   <= '0;
      best_q  <= '0;
      index_q <= '0;
      phase_q <= PH_TRY_UP;
      valid_q <= 1'b0;
    end else begin
      gains_q <= gains_d;
      steps_q <= steps_d;
      last_q  <= last_d;
      sum_q   <= sum_d;
      best_q  <= best_d;
      index_q <= index_d;
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

`ifndef SYNTHESIS
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_q <= LastIdx)
    else $error("tune index out of range");

  a_init_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_INIT) |=> sum_q == '0)
    else $error("init item did not clear the error sum");

  a_try_up_records_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_TUNE && phase_q == PH_TRY_UP)
    |=> (phase_q == PH_JUDGE_UP && best_q == $past(total_i)))
    else $error("first twiddle phase did not record the run error");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> ($stable(sum_q) && $stable(best_q) && $stable(phase_q)
                 && $stable(last_q)))
    else $error("controller state moved without an item");
`endif

endmodule

FILE: src/pstw_mac.sv
`timescale 1ns / 1ps
// middle stage: the three gain products of the pid law
// registered product terms plus the status carried alongside; uses pstw_pkg
module pstw_mac import pstw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  op_valid_i,
  output logic  op_ready_o,
  input  op_t   op_i,
  output logic  prod_valid_o,
  input  logic  prod_ready_i,
  output prod_t prod_o
);

  logic  valid_q, valid_d;
  logic  accept;
  prod_t prod_q, prod_d;

  assign op_ready_o = !valid_q || prod_ready_i;
  assign accept     = op_valid_i && op_ready_o;

  always_comb begin
    valid_d          = accept || (valid_q && !prod_ready_i);
    prod_d.is_sample = op_i.is_sample;
    prod_d.pp        = PP_WIDTH'(op_i.stat.gain_p) * PP_WIDTH'(op_i.cte);
    prod_d.pd        = PD_WIDTH'(op_i.stat.gain_d) * PD_WIDTH'(op_i.diff);
    prod_d.pi        = PI_WIDTH'(op_i.stat.gain_i) * PI_WIDTH'(op_i.sum);
    prod_d.stat      = op_i.stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = valid_q;
  assign prod_o       = prod_q;

endmodule

FILE: src/pstw_out.sv
`timescale 1ns / 1ps
// last stage: sum of terms, clamp and rounding to the steering format
// holds the result register that drives the output stream; uses pstw_pkg
module pstw_out import pstw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    prod_valid_i,
  output logic    prod_ready_o,
  input  prod_t   prod_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam logic signed [ACC_WIDTH-1:0] SteerOne  = ACC_WIDTH'(64'd1 << STEER_ONE_SHIFT);
  localparam logic signed [ACC_WIDTH-1:0] RoundHalf = ACC_WIDTH'(64'd1 << (ROUND_SHIFT - 1));
  localparam logic signed [STEER_WIDTH-1:0] SteerClamp = STEER_WIDTH'(STEER_CLAMP);

  logic                          valid_q, valid_d;
  logic                          accept;
  result_t                       res_q, res_d;
  logic signed [ACC_WIDTH-1:0]   acc, rnd_sum, rnd;
  logic signed [STEER_WIDTH-1:0] steer;

  assign prod_ready_o = !valid_q || res_ready_i;
  assign accept       = prod_valid_i && prod_ready_o;

  always_comb begin
    acc     = ACC_WIDTH'(prod_i.pp) + ACC_WIDTH'(prod_i.pd) + ACC_WIDTH'(prod_i.pi);
    rnd_sum = acc + RoundHalf;
    rnd     = rnd_sum >>> ROUND_SHIFT;
    // non-sample items drive zero; beyond plus or minus one the drive falls back to eight tenths
    if (!prod_i.is_sample) begin
      steer = '0;
    end else if (acc > SteerOne) begin
      steer = SteerClamp;
    end else if (acc < -SteerOne) begin
      steer = -SteerClamp;
    end else begin
      steer = rnd[STEER_WIDTH-1:0];
    end
  end

  always_comb begin
    valid_d        = accept || (valid_q && !res_ready_i);
    res_d.pad      = '0;
    res_d.phase    = PHASE_WIDTH'(prod_i.stat.phase);
    res_d.tune_idx = prod_i.stat.tune_idx;
    res_d.best     = prod_i.stat.best;
    res_d.gain_i   = prod_i.stat.gain_i;
    res_d.gain_d   = prod_i.stat.gain_d;
    res_d.gain_p   = prod_i.stat.gain_p;
    res_d.steer    = steer;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: bench/pstw_result_checker.sv
`timescale 1ns / 1ps
// result checker for the pid steering core: mirrors the controller and the twiddle tuner
// from accepted items and register writes and compares every result; uses pstw_pkg
module pstw_result_checker import pstw_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  // cross_track_error [15:0], run_total [47:16]
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata_i,
  // req_type [1:0]
  input  logic [REQ_WIDTH-1:0]       s_tuser_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  // steer_cmd [15:0], gain_p_now [39:16], gain_d_now [63:40], gain_i_now [87:64],
  // best_error_now [119:88], index_now [121:120], phase_now [123:122], zeros above
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef logic signed [63:0] wide_t;

  localparam longint GAIN_MAX   = (longint'(1) << (GAIN_WIDTH - 1)) - 1;
  localparam longint GAIN_MIN   = -GAIN_MAX - 1;
  localparam longint STEP_MAX   = GAIN_MAX;
  localparam longint SUM_MAX    = (longint'(1) << (SUM_WIDTH - 1)) - 1;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam longint STEER_ONE  = longint'(1) << STEER_ONE_SHIFT;
  localparam longint ROUND_HALF = longint'(1) << (ROUND_SHIFT - 1);
  localparam int     GROW_NUM   = 11;
  localparam int     SHRINK_NUM = 9;

  logic signed [GAIN_WIDTH-1:0]  cfg_gain [NUM_GAINS];
  logic [STEP_WIDTH-1:0]         cfg_step [NUM_GAINS];
  logic signed [GAIN_WIDTH-1:0]  gain     [NUM_GAINS];
  logic [STEP_WIDTH-1:0]         step_sz  [NUM_GAINS];
  logic signed [ERROR_WIDTH-1:0] last_err;
  logic signed [SUM_WIDTH-1:0]   err_sum;
  logic [TOTAL_WIDTH-1:0]        best;
  logic [IDX_WIDTH-1:0]          tune_idx;
  phase_e                        phase;
  result_t                       steer_results_due[$];
  int                            mismatches = 0;

  function automatic logic signed [GAIN_WIDTH-1:0] clamp_gain(input longint x);
    if (x > GAIN_MAX) return GAIN_WIDTH'(GAIN_MAX);
    if (x < GAIN_MIN) return GAIN_WIDTH'(GAIN_MIN);
    return GAIN_WIDTH'(x);
  endfunction

  // step * num / 10, rounding half up, kept within the unsigned step range
  function automatic logic [STEP_WIDTH-1:0] scale_step(input logic [STEP_WIDTH-1:0] s,
                                                       input int num);
    longint x;
    x = (longint'(s) * num + 5) / 10;
    if (x > STEP_MAX) return STEP_WIDTH'(STEP_MAX);
    return STEP_WIDTH'(x);
  endfunction

  function automatic logic [IDX_WIDTH-1:0] next_index(input logic [IDX_WIDTH-1:0] k);
    if (k >= IDX_WIDTH'(NUM_GAINS - 1)) return '0;
    return k + 1'b1;
  endfunction

  task automatic apply_item(input req_e req, input logic signed [ERROR_WIDTH-1:0] cte,
                            input logic [TOTAL_WIDTH-1:0] total, output result_t due);
    longint               sum_next;
    longint               acc;
    logic [IDX_WIDTH-1:0] k;
    due = '0;
    case (req)
      REQ_SAMPLE: begin
        sum_next = longint'(err_sum) + longint'(cte);
        if (sum_next > SUM_MAX) sum_next = SUM_MAX;
        else if (sum_next < SUM_MIN) sum_next = SUM_MIN;
        err_sum = SUM_WIDTH'(sum_next);
        // products stay below 2^55 at these widths, so the term limit never bites
        acc = longint'(gain[0]) * longint'(cte)
            + longint'(gain[1]) * (longint'(cte) - longint'(last_err))
            + longint'(gain[2]) * longint'(err_sum);
        last_err = cte;
        if (acc > STEER_ONE) due.steer = STEER_WIDTH'(STEER_CLAMP);
        else if (acc < -STEER_ONE) due.steer = STEER_WIDTH'(-STEER_CLAMP);
        else due.steer = STEER_WIDTH'((acc + ROUND_HALF) >>> ROUND_SHIFT);
      end
      REQ_TUNE: begin
        k = (tune_idx > IDX_WIDTH'(NUM_GAINS - 1)) ? '0 : tune_idx;
        tune_idx = k;
        case (phase)
          PH_JUDGE_UP: begin
            if (total < best) begin
              best = total;
              step_sz[k] = scale_step(step_sz[k], GROW_NUM);
              tune_idx = next_index(k);
              phase = PH_TRY_UP;
            end else begin
              gain[k] = clamp_gain(longint'(gain[k]) - 2 * longint'(step_sz[k]));
              phase = PH_JUDGE_DOWN;
            end
          end
          PH_JUDGE_DOWN: begin
            if (total < best) begin
              best = total;
              step_sz[k] = scale_step(step_sz[k], GROW_NUM);
            end else begin
              gain[k] = clamp_gain(longint'(gain[k]) + longint'(step_sz[k]));
              step_sz[k] = scale_step(step_sz[k], SHRINK_NUM);
            end
            tune_idx = next_index(k);
            phase = PH_TRY_UP;
          end
          default: begin
            best = total;
            gain[k] = clamp_gain(longint'(gain[k]) + longint'(step_sz[k]));
            phase = PH_JUDGE_UP;
          end
        endcase
      end
      REQ_INIT: begin
        // last error, best and tuner position are kept
        err_sum = '0;
        for (int i = 0; i < NUM_GAINS; i++) begin
          gain[i] = cfg_gain[i];
          step_sz[i] = cfg_step[i];
        end
      end
      default: ;
    endcase
    due.gain_p   = gain[0];
    due.gain_d   = gain[1];
    due.gain_i   = gain[2];
    due.best     = best;
    due.tune_idx = tune_idx;
    due.phase    = phase;
  endtask

  function automatic int field_differs(input string name, input wide_t want, input wide_t got);
    if (want === got) return 0;
    $error("%s: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    if (steer_results_due.size() == 0) begin
      $error("result item with no input item waiting");
      mismatches++;
    end else begin
      want = steer_results_due.pop_front();
      mismatches += field_differs("steer_cmd", wide_t'(want.steer), wide_t'(got.steer))
                  + field_differs("gain_p_now", wide_t'(want.gain_p), wide_t'(got.gain_p))
                  + field_differs("gain_d_now", wide_t'(want.gain_d), wide_t'(got.gain_d))
                  + field_differs("gain_i_now", wide_t'(want.gain_i), wide_t'(got.gain_i))
                  + field_differs("best_error_now", wide_t'(want.best), wide_t'(got.best))
                  + field_differs("index_now", wide_t'(want.tune_idx), wide_t'(got.tune_idx))
                  + field_differs("phase_now", wide_t'(want.phase), wide_t'(got.phase))
                  + field_differs("pad", wide_t'(want.pad), wide_t'(got.pad));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GAINS; i++) begin
        cfg_gain[i] = '0;
        cfg_step[i] = '0;
        gain[i]     = '0;
        step_sz[i]  = '0;
      end
      last_err = '0;
      err_sum  = '0;
      best     = '0;
      tune_idx = '0;
      phase    = PH_TRY_UP;
      steer_results_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_INIT_GAIN_P: cfg_gain[0] = cfg_data_i;
          CFG_INIT_GAIN_D: cfg_gain[1] = cfg_data_i;
          CFG_INIT_GAIN_I: cfg_gain[2] = cfg_data_i;
          CFG_INIT_STEP_P: cfg_step[0] = cfg_data_i[STEP_WIDTH-1:0];
          CFG_INIT_STEP_D: cfg_step[1] = cfg_data_i[STEP_WIDTH-1:0];
          CFG_INIT_STEP_I: cfg_step[2] = cfg_data_i[STEP_WIDTH-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        apply_item(req_e'(s_tuser_i), s_tdata_i[ERROR_WIDTH-1:0],
                   s_tdata_i[ERROR_WIDTH +: TOTAL_WIDTH], due);
        steer_results_due.push_back(due);
      end
      if (m_tvalid_i && m_tready_i) check_result(result_t'(m_tdata_i));
      pending_o    <= steer_results_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: bench/tb_pid_steer_with_twiddle_tuning_core.sv
`timescale 1ns / 1ps
// testbench top for pid_steer_with_twiddle_tuning_core: clock, reset, register writes
// and item stimulus with random idling; checking is done by pstw_result_checker
module tb_pid_steer_with_twiddle_tuning_core;
  import pstw_pkg::*;

  typedef enum int {STYLE_MILD, STYLE_WIDE, STYLE_TOP, STYLE_BOTTOM} cfg_style_e;

  localparam logic [REQ_WIDTH-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [CFG_DATA_WIDTH-1:0] GAIN_ONE    = 24'h010000;
  localparam logic [CFG_DATA_WIDTH-1:0] GAIN_HALF   = 24'h008000;
  localparam logic [CFG_DATA_WIDTH-1:0] GAIN_TINY   = 24'h000100;
  localparam logic [CFG_DATA_WIDTH-1:0] GAIN_TOP    = 24'h7FFFFF;
  localparam logic [CFG_DATA_WIDTH-1:0] GAIN_BOTTOM = 24'h800000;
  localparam logic [CFG_DATA_WIDTH-1:0] STEP_OVER   = 24'hFFFFFF;
  localparam logic [ERROR_WIDTH-1:0]    ERR_MAX     = 16'h7FFF;
  localparam logic [ERROR_WIDTH-1:0]    ERR_MIN     = 16'h8000;

  localparam int          PHASE_COUNT = 6;
  localparam int          PHASE_ITEMS = 180;
  localparam int          IDLE_PCT    = 16;
  localparam int          CALM_FROM   = 600;
  localparam int          CALM_TO     = 800;
  localparam int          HOLD_AT     = 300;
  localparam int          HOLD_CYCLES = 80;
  localparam int          SUM_RUN     = 16;
  localparam int          STALL_LIMIT = 2000;
  localparam int          END_CYCLES  = 8;
  localparam int unsigned GAIN_SPAN   = 65536;
  localparam int unsigned ISUM_SPAN   = 1024;
  localparam int unsigned STEP_MILD   = 16384;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata;
  logic [REQ_WIDTH-1:0]       s_axis_tuser;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index_i;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i;
  int                         fail_count;
  int                         pending_results;
  int                         n_sent = 0;

  always #1 clk_i = ~clk_i;

  pid_steer_with_twiddle_tuning_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pstw_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_gain(input cfg_style_e style,
                                                          input int unsigned span);
    case (style)
      STYLE_WIDE:   return CFG_DATA_WIDTH'($urandom);
      STYLE_TOP:    return GAIN_TOP;
      STYLE_BOTTOM: return GAIN_BOTTOM;
      default:      return CFG_DATA_WIDTH'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  // bit 23 of a step write is set now and then; the block drops it
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_step(input cfg_style_e style);
    case (style)
      STYLE_WIDE:   return CFG_DATA_WIDTH'($urandom);
      STYLE_TOP:    return STEP_OVER;
      STYLE_BOTTOM: return '0;
      default:      return CFG_DATA_WIDTH'($urandom_range(0, STEP_MILD));
    endcase
  endfunction

  function automatic logic [ERROR_WIDTH-1:0] rand_cte();
    if ($urandom_range(0, 3) == 0) return ERROR_WIDTH'($urandom);
    return ERROR_WIDTH'($urandom_range(0, 2048) - 1024);
  endfunction

  // small totals make the tuner comparisons go both ways
  function automatic logic [TOTAL_WIDTH-1:0] rand_total();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  task automatic push_item(input logic [REQ_WIDTH-1:0] req, input logic [ERROR_WIDTH-1:0] cte,
                           input logic [TOTAL_WIDTH-1:0] total);
    while (!(n_sent >= CALM_FROM && n_sent < CALM_TO) && $urandom_range(0, 99) < IDLE_PCT)
    begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {total, cte};
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_regs(input logic [CFG_DATA_WIDTH-1:0] gp, gd, gi, sp, sd, si);
    write_reg(CFG_INIT_GAIN_P, gp);
    write_reg(CFG_INIT_GAIN_D, gd);
    write_reg(CFG_INIT_GAIN_I, gi);
    write_reg(CFG_INIT_STEP_P, sp);
    write_reg(CFG_INIT_STEP_D, sd);
    write_reg(CFG_INIT_STEP_I, si);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    cfg_style_e            style;
    int unsigned           roll;
    logic [REQ_WIDTH-1:0]  req;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // mild gains: clamping both ways, small errors, every tuner phase and branch
    load_regs(GAIN_ONE, GAIN_HALF, GAIN_TINY, 24'h001000, 24'h000800, 24'h000400);
    push_item(REQ_INIT, '0, '0);
    push_item(REQ_SAMPLE, ERR_MAX, '1);
    push_item(REQ_SAMPLE, ERR_MIN, '0);
    push_item(REQ_SAMPLE, '0, '0);
    push_item(REQ_SAMPLE, ERROR_WIDTH'(1), '0);
    push_item(REQ_SAMPLE, '1, '0);
    push_item(REQ_SAMPLE, ERROR_WIDTH'(100), '0);
    push_item(REQ_UNKNOWN, ERR_MAX, '1);
    push_item(REQ_TUNE, '0, 32'd1000);
    push_item(REQ_TUNE, '0, 32'd500);
    push_item(REQ_TUNE, '0, 32'd1000);
    push_item(REQ_TUNE, '0, 32'd2000);
    push_item(REQ_TUNE, '0, 32'd100);
    push_item(REQ_TUNE, '0, '0);
    push_item(REQ_TUNE, '0, '0);
    push_item(REQ_TUNE, '0, '1);
    push_item(REQ_SAMPLE, ERROR_WIDTH'(-300), '0);
    push_item(REQ_SAMPLE, ERROR_WIDTH'(300), '0);
    drain_results();

    // extreme gains and oversized steps: gains and steps run into their limits
    load_regs(GAIN_TOP, GAIN_BOTTOM, GAIN_TOP, STEP_OVER, STEP_OVER, STEP_OVER);
    push_item(REQ_INIT, '0, '0);
    push_item(REQ_TUNE, '0, 32'd10);
    push_item(REQ_TUNE, '0, 32'd5);
    push_item(REQ_TUNE, '0, 32'd10);
    push_item(REQ_TUNE, '0, 32'd20);
    push_item(REQ_TUNE, '0, 32'd30);
    push_item(REQ_SAMPLE, ERR_MAX, '0);
    push_item(REQ_SAMPLE, ERR_MIN, '0);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      style = cfg_style_e'(p % 4);
      load_regs(pick_gain(style, GAIN_SPAN), pick_gain(style, GAIN_SPAN),
                pick_gain(style, ISUM_SPAN), pick_step(style), pick_step(style),
                pick_step(style));
      push_item(REQ_INIT, rand_cte(), rand_total());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 60) req = REQ_SAMPLE;
        else if (roll < 88) req = REQ_TUNE;
        else if (roll < 94) req = REQ_INIT;
        else req = REQ_UNKNOWN;
        push_item(req, rand_cte(), rand_total());
      end
    end

    // short runs at the error extremes push the error sum hard both ways
    drain_results();
    load_regs(GAIN_HALF, GAIN_TINY, GAIN_TINY, '0, '0, '0);
    push_item(REQ_INIT, '0, '0);
    for (int n = 0; n < SUM_RUN; n++) push_item(REQ_SAMPLE, ERR_MAX, rand_total());
    push_item(REQ_INIT, '0, '0);
    for (int n = 0; n < SUM_RUN; n++) push_item(REQ_SAMPLE, ERR_MIN, rand_total());

    drain_results();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off so the pipeline backs up, one calm stretch
  initial begin
    int taken;
    int hold_left;
    bit hold_done;
    taken     = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
      if (!hold_done && taken >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (taken >= CALM_FROM && taken < CALM_TO) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // ends a run that stops moving
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
src/pstw_pkg.sv
src/pstw_ctrl.sv
src/pstw_mac.sv
src/pstw_out.sv
src/pid_steer_with_twiddle_tuning_core.sv
bench/pstw_result_checker.sv
bench/tb_pid_steer_with_twiddle_tuning_core.sv
